// ----- hdl/rif_pkg.sv -----
// Package for the radix integer formatter: payload structs, command format,
// sizing constants and the character helper functions.
// No dependencies; rif_front, rif_queue, rif_back and the top level import this package.
`default_nettype none

package rif_pkg;

  // Sizing
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_RADIX   = 36;
  localparam int WORD_MAX    = 10;
  localparam int COL_W       = 7;
  localparam int RADIX_W     = 6;

  // Divider: DIV_STEP quotient bits per cycle
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_BITS   = DIV_CYCLES * DIV_STEP;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Digit store
  localparam int DIG_ADDR_W = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W  = $clog2(VALUE_WIDTH + 1);

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Characters
  localparam logic [15:0] CHAR_MINUS = 16'h002D;
  localparam logic [15:0] CHAR_PLUS  = 16'h002B;
  localparam logic [15:0] CHAR_NONE  = 16'h0000;
  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_ALPHA = 8'h37;  // 'A' minus ten
  localparam logic [RADIX_W-1:0] DEC_RADIX = RADIX_W'(10);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]            radix;
    logic                          has_mincol;
    logic [COL_W-1:0]              mincol;
    logic [15:0]                   pad_char;
    logic                          at_flag;
    logic                          colon_flag;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_char;
    logic        last;
    logic        radix_error;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_ERR,
    CMD_WORD,
    CMD_NUM
  } cmd_kind_t;

  typedef enum logic [1:0] {
    WORD_CARD,
    WORD_ORD,
    WORD_ROMAN,
    WORD_OLD_ROMAN
  } word_sel_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [VALUE_WIDTH-1:0] mag;
    logic [RADIX_W-1:0]     radix;
    logic                   has_sign;
    logic                   sign_minus;
    logic [COL_W-1:0]       cols;
    logic [15:0]            pad_char;
    word_sel_t              word_sel;
    logic [3:0]             word_idx;
  } cmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

  // Digit value to character, uppercase above nine
  function automatic logic [15:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    return {8'h00, (d8 < 8'd10) ? (CHAR_ZERO + d8) : (CHAR_ALPHA + d8)};
  endfunction

  // Word text, right-justified, zero bytes above the first character
  function automatic logic [63:0] word_text(input word_sel_t sel,
                                            input logic [3:0] idx);
    logic [63:0] t;
    t = '0;
    unique case (sel)
      WORD_CARD: begin
        case (idx)
          4'd0:    t = 64'("zero");
          4'd1:    t = 64'("one");
          4'd2:    t = 64'("two");
          4'd3:    t = 64'("three");
          4'd4:    t = 64'("four");
          4'd5:    t = 64'("five");
          4'd6:    t = 64'("six");
          4'd7:    t = 64'("seven");
          4'd8:    t = 64'("eight");
          4'd9:    t = 64'("nine");
          default: t = 64'("ten");
        endcase
      end
      WORD_ORD: begin
        case (idx)
          4'd0:    t = 64'("zeroth");
          4'd1:    t = 64'("first");
          4'd2:    t = 64'("second");
          4'd3:    t = 64'("third");
          4'd4:    t = 64'("fourth");
          4'd5:    t = 64'("fifth");
          4'd6:    t = 64'("sixth");
          4'd7:    t = 64'("seventh");
          4'd8:    t = 64'("eighth");
          4'd9:    t = 64'("ninth");
          default: t = 64'("tenth");
        endcase
      end
      WORD_ROMAN: begin
        case (idx)
          4'd0:    t = 64'("0");
          4'd1:    t = 64'("I");
          4'd2:    t = 64'("II");
          4'd3:    t = 64'("III");
          4'd4:    t = 64'("IV");
          4'd5:    t = 64'("V");
          4'd6:    t = 64'("VI");
          4'd7:    t = 64'("VII");
          4'd8:    t = 64'("VIII");
          4'd9:    t = 64'("IX");
          default: t = 64'("X");
        endcase
      end
      default: begin
        case (idx)
          4'd0:    t = 64'("0");
          4'd1:    t = 64'("I");
          4'd2:    t = 64'("II");
          4'd3:    t = 64'("III");
          4'd4:    t = 64'("IIII");
          4'd5:    t = 64'("V");
          4'd6:    t = 64'("VI");
          4'd7:    t = 64'("VII");
          4'd8:    t = 64'("VIII");
          4'd9:    t = 64'("VIIII");
          default: t = 64'("X");
        endcase
      end
    endcase
    return t;
  endfunction

  // Count the character bytes of a word text
  function automatic logic [3:0] word_len(input logic [63:0] t);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(t[8*i +: 8] != 8'h00);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rif_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/rif_front.sv -----
// Front end: accepts directives and classifies them into queue commands.
// Depends on rif_pkg.
`default_nettype none

module rif_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  rif_pkg::in_item_t  in_data,
  input  rif_pkg::q_stat_t   q_stat,
  output logic               push,
  output rif_pkg::cmd_t      push_cmd
);

  import rif_pkg::*;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  logic                   bad_radix;
  logic                   word_mode;
  logic                   word_in_range;
  logic [COL_W-1:0]       cols;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Magnitude without overflow at the most negative value
  assign raw = in_data.value;
  assign neg = raw[VALUE_WIDTH-1];
  assign mag = neg ? VALUE_WIDTH'(~raw + VALUE_WIDTH'(1)) : raw;

  assign bad_radix     = (in_data.radix == RADIX_W'(1)) ||
                         (in_data.radix > RADIX_W'(MAX_RADIX));
  assign word_mode     = (in_data.radix == '0);
  assign word_in_range = !neg && (mag <= VALUE_WIDTH'(WORD_MAX));

  // Saturate the column request
  always_comb begin
    if (!in_data.has_mincol) begin
      cols = '0;
    end else if (in_data.mincol > COL_W'(MAX_COLUMNS)) begin
      cols = COL_W'(MAX_COLUMNS);
    end else begin
      cols = in_data.mincol;
    end
  end

  // Classify the directive
  always_comb begin
    push_cmd            = '0;
    push_cmd.mag        = mag;
    push_cmd.pad_char   = in_data.pad_char;
    push_cmd.word_idx   = mag[3:0];
    push_cmd.sign_minus = neg;
    if (in_data.at_flag && in_data.colon_flag) begin
      push_cmd.word_sel = WORD_OLD_ROMAN;
    end else if (in_data.at_flag) begin
      push_cmd.word_sel = WORD_ROMAN;
    end else if (in_data.colon_flag) begin
      push_cmd.word_sel = WORD_ORD;
    end else begin
      push_cmd.word_sel = WORD_CARD;
    end
    if (bad_radix) begin
      push_cmd.kind = CMD_ERR;
    end else if (word_mode && word_in_range) begin
      push_cmd.kind = CMD_WORD;
    end else if (word_mode) begin
      // plain decimal, no plus, no padding
      push_cmd.kind     = CMD_NUM;
      push_cmd.radix    = DEC_RADIX;
      push_cmd.has_sign = neg;
      push_cmd.cols     = '0;
    end else begin
      push_cmd.kind     = CMD_NUM;
      push_cmd.radix    = in_data.radix;
      push_cmd.has_sign = neg || (in_data.at_flag && (mag != '0));
      push_cmd.cols     = cols;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rif_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on rif_pkg.
`default_nettype none

module rif_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rif_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output logic              pop_valid,
  output rif_pkg::cmd_t     pop_cmd,
  output rif_pkg::q_stat_t  stat
);

  import rif_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign do_push = push && (count_r != QCNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_valid   = (count_r != '0);
  assign pop_cmd     = slot_r[rd_ptr_r];
  assign stat.count  = count_r;
  assign stat.full   = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty  = (count_r == '0);

endmodule

`default_nettype wire

// ----- hdl/rif_back.sv -----
// Back end: divides out the digits into the digit store, then emits padding,
// sign and digits (or word text, or the error result) one per cycle while the output is not stalled.
// Depends on rif_pkg and rif_ram.
`default_nettype none

module rif_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  rif_pkg::cmd_t        q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rif_pkg::out_item_t   out_data,
  output rif_pkg::back_stat_t  stat
);

  import rif_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PREP,
    S_PAD,
    S_SIGN,
    S_DIG,
    S_WORD,
    S_ERR
  } state_t;

  state_t                state_r, state_nxt;
  logic [DIV_BITS-1:0]   quo_r, quo_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [DIG_CNT_W-1:0]  nd_r, nd_nxt;
  logic [DIG_ADDR_W-1:0] dig_idx_r, dig_idx_nxt;
  logic [COL_W-1:0]      pad_cnt_r, pad_cnt_nxt;
  logic [COL_W-1:0]      cols_r, cols_nxt;
  logic                  has_sign_r, has_sign_nxt;
  logic                  sign_minus_r, sign_minus_nxt;
  logic [15:0]           pad_char_r, pad_char_nxt;
  logic [63:0]           word_txt_r, word_txt_nxt;
  logic [3:0]            word_cnt_r, word_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [DIV_BITS-1:0]   div_quo;
  logic [RADIX_W-1:0]    div_rem;
  logic [RADIX_W:0]      div_t;
  logic                  div_last;
  logic [RADIX_W-1:0]    dig_rd;
  logic                  emitting;
  logic                  load;
  out_item_t             cur;
  logic [63:0]           new_txt;
  logic [3:0]            new_len;
  logic [3:0]            word_sh;
  logic [COL_W-1:0]      text_len;

  // Digit store
  rif_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_WIDTH)
  ) u_dig_ram (
    .clk     (clk),
    .wr_en   ((state_r == S_DIV) && div_last),
    .wr_addr (nd_r[DIG_ADDR_W-1:0]),
    .wr_data (div_rem),
    .rd_addr (dig_idx_nxt),
    .rd_data (dig_rd)
  );

  // Restoring division, DIV_STEP quotient bits per cycle
  always_comb begin
    div_quo = quo_r;
    div_rem = rem_r;
    div_t   = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      div_t   = {div_rem, div_quo[DIV_BITS-1]};
      div_quo = {div_quo[DIV_BITS-2:0], 1'b0};
      if (div_t >= {1'b0, radix_r}) begin
        div_rem    = RADIX_W'(div_t - {1'b0, radix_r});
        div_quo[0] = 1'b1;
      end else begin
        div_rem = RADIX_W'(div_t);
      end
    end
  end

  assign div_last = (div_cnt_r == DIV_CNT_W'(DIV_CYCLES - 1));

  // Word text, left-justified for shifting out
  assign new_txt  = word_text(q_cmd.word_sel, q_cmd.word_idx);
  assign new_len  = word_len(new_txt);
  assign word_sh  = 4'd8 - new_len;
  assign text_len = COL_W'(nd_r) + COL_W'(has_sign_r);

  assign emitting = (state_r == S_PAD) || (state_r == S_SIGN) || (state_r == S_DIG) ||
                    (state_r == S_WORD) || (state_r == S_ERR);
  assign load     = emitting && (!out_valid_r || out_ready);
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // Select the current character
  always_comb begin
    cur = '0;
    unique case (state_r)
      S_PAD:  cur.out_char = pad_char_r;
      S_SIGN: cur.out_char = sign_minus_r ? CHAR_MINUS : CHAR_PLUS;
      S_DIG: begin
        cur.out_char = digit_char(dig_rd);
        cur.last     = (dig_idx_r == '0);
      end
      S_WORD: begin
        cur.out_char = {8'h00, word_txt_r[63:56]};
        cur.last     = (word_cnt_r == 4'd1);
      end
      S_ERR: begin
        cur.out_char    = CHAR_NONE;
        cur.last        = 1'b1;
        cur.radix_error = 1'b1;
      end
      default: cur = '0;
    endcase
  end

  // Sequence the item
  always_comb begin
    state_nxt      = state_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    radix_nxt      = radix_r;
    div_cnt_nxt    = div_cnt_r;
    nd_nxt         = nd_r;
    dig_idx_nxt    = dig_idx_r;
    pad_cnt_nxt    = pad_cnt_r;
    cols_nxt       = cols_r;
    has_sign_nxt   = has_sign_r;
    sign_minus_nxt = sign_minus_r;
    pad_char_nxt   = pad_char_r;
    word_txt_nxt   = word_txt_r;
    word_cnt_nxt   = word_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          quo_nxt        = DIV_BITS'(q_cmd.mag);
          rem_nxt        = '0;
          radix_nxt      = q_cmd.radix;
          div_cnt_nxt    = '0;
          nd_nxt         = '0;
          cols_nxt       = q_cmd.cols;
          has_sign_nxt   = q_cmd.has_sign;
          sign_minus_nxt = q_cmd.sign_minus;
          pad_char_nxt   = q_cmd.pad_char;
          word_txt_nxt   = new_txt << {word_sh, 3'b000};
          word_cnt_nxt   = new_len;
          unique case (q_cmd.kind)
            CMD_ERR:  state_nxt = S_ERR;
            CMD_WORD: state_nxt = S_WORD;
            default:  state_nxt = S_DIV;
          endcase
        end
      end
      S_DIV: begin
        quo_nxt     = div_quo;
        rem_nxt     = div_rem;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          // store the digit, then restart on the quotient or finish
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          nd_nxt      = nd_r + DIG_CNT_W'(1);
          dig_idx_nxt = nd_r[DIG_ADDR_W-1:0];
          if (div_quo == '0) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        pad_cnt_nxt = (cols_r > text_len) ? (cols_r - text_len) : '0;
        if (cols_r > text_len) begin
          state_nxt = S_PAD;
        end else if (has_sign_r) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_DIG;
        end
      end
      S_PAD: begin
        if (load) begin
          pad_cnt_nxt = pad_cnt_r - COL_W'(1);
          if (pad_cnt_r == COL_W'(1)) begin
            state_nxt = has_sign_r ? S_SIGN : S_DIG;
          end
        end
      end
      S_SIGN: begin
        if (load) begin
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (load) begin
          if (dig_idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            dig_idx_nxt = dig_idx_r - DIG_ADDR_W'(1);
          end
        end
      end
      S_WORD: begin
        if (load) begin
          word_txt_nxt = {word_txt_r[55:0], 8'h00};
          word_cnt_nxt = word_cnt_r - 4'd1;
          if (word_cnt_r == 4'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_data_nxt  = cur;
      out_valid_nxt = 1'b1;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    radix_r      <= radix_nxt;
    div_cnt_r    <= div_cnt_nxt;
    nd_r         <= nd_nxt;
    dig_idx_r    <= dig_idx_nxt;
    pad_cnt_r    <= pad_cnt_nxt;
    cols_r       <= cols_nxt;
    has_sign_r   <= has_sign_nxt;
    sign_minus_r <= sign_minus_nxt;
    pad_char_r   <= pad_char_nxt;
    word_txt_r   <= word_txt_nxt;
    word_cnt_r   <= word_cnt_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign stat.busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ----- hdl/radix_integer_formatter.sv -----
// Top level of the radix integer formatter: front end, command queue, back end.
// Depends on rif_pkg, rif_front, rif_queue, rif_back (and rif_ram below it).
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------------
//   in_      | input     | in_valid / in_ready   | in_data  (rif_pkg::in_item_t)
//   out_     | output    | out_valid / out_ready | out_data (rif_pkg::out_item_t)
//
// A bad radix or a word goes from idle straight to its characters. A number first divides
// out its D digits, then passes a prep state and emits max(text length, columns) characters;
// the divider yields 8 quotient bits a cycle.
// Reset is synchronous and active low; the queue starts empty and the back end idle.
// The queue holds two commands, so directives are taken while the back end works;
// a stalled output holds the back end, not the front end, until the queue fills.
`default_nettype none

module radix_integer_formatter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rif_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rif_pkg::out_item_t  out_data
);

  import rif_pkg::*;

  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  logic       pop_valid;
  cmd_t       pop_cmd;
  q_stat_t    q_stat;
  back_stat_t back_stat;

  rif_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rif_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .stat      (q_stat)
  );

  rif_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (back_stat)
  );

  // An error result is a lone, final, null character
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.radix_error |-> out_data.last && (out_data.out_char == CHAR_NONE))
    else $error("radix error result not a single final character");

  // With the back end idle, only a final character may wait at the output
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    !back_stat.busy && out_valid |-> out_data.last)
    else $error("item output cut short");

  // A full queue takes no transaction, and a push lands in the queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !pop |=> q_stat.count == $past(q_stat.count) + QCNT_W'(1))
    else $error("accepted transaction lost at the queue");

endmodule

`default_nettype wire

// ----- sim/radix_integer_formatter_test.sv -----
// Self-checking testbench for radix_integer_formatter: directed and random
// directives in, characters out, each checked against an internal text predictor.
// Depends on rif_pkg and the formatter RTL in hdl/.
`timescale 1ns / 100ps

module radix_integer_formatter_test;
  import rif_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_ITEMS = 295;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 250;

  localparam logic [RADIX_W-1:0] WORD_RADIX = '0;
  localparam int                 DECIMAL    = 10;
  localparam logic [15:0] PAD_SPACE   = 16'h0020;
  localparam logic [15:0] CH_DIGIT0   = 16'h0030;
  localparam logic [15:0] CH_LETTER_A = 16'h0041;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Directives waiting to be driven, with a flag to drain the block first
  in_item_t  pending_directives[$];
  bit        drain_first[$];
  // Characters the block still owes, oldest first
  out_item_t expected_chars[$];

  logic        in_took = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_left = 0;
  int          idle_cycles = 0;
  int          error_count = 0;

  string cardinal_words[11] = '{"zero", "one", "two", "three", "four", "five",
                                "six", "seven", "eight", "nine", "ten"};
  string ordinal_words[11] = '{"zeroth", "first", "second", "third", "fourth",
                               "fifth", "sixth", "seventh", "eighth", "ninth",
                               "tenth"};
  string roman_words[11] = '{"0", "I", "II", "III", "IV", "V", "VI", "VII",
                             "VIII", "IX", "X"};
  string old_roman_words[11] = '{"0", "I", "II", "III", "IIII", "V", "VI", "VII",
                                 "VIII", "VIIII", "X"};

  radix_integer_formatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Work out the characters one directive produces and queue them
  function automatic void predict_text(input in_item_t item);
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [VALUE_WIDTH-1:0] base;
    logic [VALUE_WIDTH-1:0] digit;
    logic                   negative;
    logic [15:0]            body[$];
    string                  word;
    int                     columns;
    word_sel_t              sel;
    out_item_t              res;
    negative  = item.value[VALUE_WIDTH-1];
    magnitude = item.value;
    if (negative) begin
      magnitude = ~magnitude + 1'b1;
    end
    // bad radix: one error marker and nothing else
    if (item.radix == 1 || item.radix > MAX_RADIX) begin
      res.out_char    = CHAR_NONE;
      res.last        = 1'b1;
      res.radix_error = 1'b1;
      expected_chars.push_back(res);
      return;
    end
    if (item.radix == WORD_RADIX && !negative && magnitude <= WORD_MAX) begin
      // word text; the flags pick the style
      if (item.at_flag && item.colon_flag) sel = WORD_OLD_ROMAN;
      else if (item.at_flag) sel = WORD_ROMAN;
      else if (item.colon_flag) sel = WORD_ORD;
      else sel = WORD_CARD;
      case (sel)
        WORD_CARD:  word = cardinal_words[magnitude];
        WORD_ORD:   word = ordinal_words[magnitude];
        WORD_ROMAN: word = roman_words[magnitude];
        default:    word = old_roman_words[magnitude];
      endcase
      for (int k = 0; k < word.len(); k++) begin
        body.push_back({8'h00, word[k]});
      end
    end else begin
      // digits, least significant found first
      base = (item.radix == WORD_RADIX) ? DECIMAL : item.radix;
      if (magnitude == 0) begin
        body.push_back(CH_DIGIT0);
      end else begin
        while (magnitude != 0) begin
          digit     = magnitude % base;
          magnitude = magnitude / base;
          body.push_front((digit < DECIMAL) ? CH_DIGIT0 + 16'(digit)
                                            : CH_LETTER_A + 16'(digit - DECIMAL));
        end
        if (negative) body.push_front(CHAR_MINUS);
        else if (item.at_flag && item.radix != WORD_RADIX) body.push_front(CHAR_PLUS);
      end
      // left pad in digit mode only, width capped at the column limit
      if (item.radix != WORD_RADIX && item.has_mincol) begin
        columns = (item.mincol > MAX_COLUMNS) ? MAX_COLUMNS : item.mincol;
        while (body.size() < columns) body.push_front(item.pad_char);
      end
    end
    while (body.size() > MAX_COLUMNS) void'(body.pop_back());
    for (int k = 0; k < body.size(); k++) begin
      res.out_char    = body[k];
      res.last        = (k == body.size() - 1);
      res.radix_error = 1'b0;
      expected_chars.push_back(res);
    end
  endfunction

  function automatic in_item_t directive(input logic signed [VALUE_WIDTH-1:0] value,
                                         input int radix, input bit has_mincol,
                                         input int mincol, input logic [15:0] pad,
                                         input bit at_flag, input bit colon_flag);
    in_item_t d;
    d.value      = value;
    d.radix      = RADIX_W'(radix);
    d.has_mincol = has_mincol;
    d.mincol     = COL_W'(mincol);
    d.pad_char   = pad;
    d.at_flag    = at_flag;
    d.colon_flag = colon_flag;
    return d;
  endfunction

  function automatic in_item_t random_directive();
    in_item_t d;
    int       pick;
    // value: full range, small, extremes, random magnitude widths
    case ($urandom_range(0, 5))
      1: d.value = $urandom_range(0, 12);
      2: d.value = -$signed($urandom_range(1, 12));
      3: begin
        case ($urandom_range(0, 3))
          0: d.value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
          1: d.value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
          2: d.value = '1;
          default: d.value = '0;
        endcase
      end
      4: begin
        d.value = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
        if ($urandom_range(0, 1)) d.value = -d.value;
      end
      default: d.value = $urandom;
    endcase
    // radix: mostly digit bases, some word mode, some bad
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      d.radix = WORD_RADIX;
      if ($urandom_range(0, 3) != 0) d.value = $signed($urandom_range(0, 14)) - 2;
    end else if (pick < 5) begin
      pick    = $urandom_range(0, 63 - MAX_RADIX);
      d.radix = RADIX_W'((pick == 0) ? 1 : MAX_RADIX + pick);
    end else if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: d.radix = RADIX_W'(2);
        1: d.radix = RADIX_W'(8);
        2: d.radix = RADIX_W'(16);
        default: d.radix = RADIX_W'(DECIMAL);
      endcase
    end else begin
      d.radix = RADIX_W'($urandom_range(2, MAX_RADIX));
    end
    d.has_mincol = $urandom_range(0, 1);
    d.mincol     = COL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 40));
    d.pad_char   = ($urandom_range(0, 3) == 0) ? PAD_SPACE : 16'($urandom);
    d.at_flag    = $urandom_range(0, 1);
    d.colon_flag = $urandom_range(0, 1);
    return d;
  endfunction

  task automatic queue_directive(input in_item_t d, input bit drain);
    pending_directives.push_back(d);
    drain_first.push_back(drain);
  endtask

  // Drive directives in bursts; hold each transaction until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_directives.size() == 0 ||
                 (drain_first[0] && expected_chars.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      in_data  <= pending_directives.pop_front();
      void'(drain_first.pop_front());
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 16);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Stall the result side on a rotating pattern, renewed now and then
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hFFFF;
        1: ready_pattern <= 16'($urandom) | 16'h0001;
        2: ready_pattern <= 16'h0001;
        default: ready_pattern <= 16'($urandom) | 16'($urandom);
      endcase
      pattern_left <= $urandom_range(20, 120);
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      pattern_left  <= pattern_left - 1;
    end
    out_ready <= ready_pattern[0];
  end

  // Predict on each accepted directive, check each accepted character
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_took     <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) predict_text(in_data);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character %h, nothing pending", out_data.out_char);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, out_data.out_char);
            error_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data.last);
            error_count++;
          end
          if (out_data.radix_error !== want.radix_error) begin
            $error("radix_error: expected %b, got %b",
                   want.radix_error, out_data.radix_error);
            error_count++;
          end
        end
      end
      // watchdog: give up after a long stretch with no transaction
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // directed: extremes, signs, padding, bad radix, every word style
    queue_directive(directive(0, DECIMAL, 0, 0, PAD_SPACE, 0, 0), 0);
    queue_directive(directive(32'sh7FFFFFFF, MAX_RADIX, 0, 0, PAD_SPACE, 0, 0), 0);
    queue_directive(directive(32'sh80000000, 2, 1, 127, 16'hFFFF, 0, 0), 0);
    queue_directive(directive(-1, 16, 0, 0, PAD_SPACE, 1, 0), 0);
    queue_directive(directive(12345, DECIMAL, 1, 12, 16'h002A, 1, 0), 0);
    queue_directive(directive(0, DECIMAL, 1, 1, PAD_SPACE, 1, 1), 0);
    queue_directive(directive(32'sh7FFFFFFF, 2, 1, MAX_COLUMNS, 16'h0000, 0, 0), 0);
    queue_directive(directive(35, MAX_RADIX, 0, 0, PAD_SPACE, 0, 1), 0);
    queue_directive(directive(-100, 3, 0, 50, PAD_SPACE, 0, 0), 0);
    queue_directive(directive(42, 1, 1, 10, PAD_SPACE, 0, 0), 0);
    queue_directive(directive(42, MAX_RADIX + 1, 0, 0, PAD_SPACE, 1, 0), 0);
    queue_directive(directive(-7, 63, 1, 127, 16'hFFFF, 1, 1), 0);
    queue_directive(directive(4, WORD_RADIX, 0, 0, PAD_SPACE, 0, 0), 0);
    queue_directive(directive(4, WORD_RADIX, 0, 0, PAD_SPACE, 0, 1), 0);
    queue_directive(directive(4, WORD_RADIX, 0, 0, PAD_SPACE, 1, 0), 0);
    queue_directive(directive(4, WORD_RADIX, 0, 0, PAD_SPACE, 1, 1), 0);
    queue_directive(directive(9, WORD_RADIX, 0, 0, PAD_SPACE, 1, 1), 0);
    queue_directive(directive(0, WORD_RADIX, 1, 20, 16'h002E, 0, 0), 0);
    queue_directive(directive(WORD_MAX, WORD_RADIX, 0, 0, PAD_SPACE, 0, 1), 0);
    queue_directive(directive(0, WORD_RADIX, 0, 0, PAD_SPACE, 1, 0), 0);
    queue_directive(directive(-3, WORD_RADIX, 1, 8, PAD_SPACE, 1, 0), 0);
    queue_directive(directive(WORD_MAX + 1, WORD_RADIX, 1, 30, PAD_SPACE, 1, 1), 0);
    queue_directive(directive(32'sh80000000, WORD_RADIX, 0, 0, PAD_SPACE, 0, 0), 0);
    queue_directive(directive(255, 16, 1, 0, PAD_SPACE, 0, 0), 0);
    queue_directive(directive(1, MAX_RADIX - 1, 1, 65, 16'h005F, 1, 0), 0);

    // random: drain fully before the first and a middle directive, and now and then at random
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      queue_directive(random_directive(),
                      k == 0 || k == RANDOM_ITEMS / 2 || $urandom_range(0, 99) == 0);
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // wait for the last transaction, then for all its characters
    while (pending_directives.size() != 0 || in_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rif_pkg.sv
hdl/rif_ram.sv
hdl/rif_front.sv
hdl/rif_queue.sv
hdl/rif_back.sv
hdl/radix_integer_formatter.sv
sim/radix_integer_formatter_test.sv
